### rtl/snp_pkg.sv
// snp_pkg: shared widths, word types and lane codes for the segment nearest points unit
// no dependencies; imported by segment_nearest_points_unit
`timescale 1ns / 1ps

package snp_pkg;

  localparam int CoordW = 16;          // signed q8.8 coordinate
  localparam int DiffW  = CoordW + 1;  // endpoint differences
  localparam int DotW   = 2 * DiffW + 1; // three-term dot products
  localparam int LenW   = DotW - 1;    // squared segment length, never negative
  localparam int TW     = DotW + 1;    // projection numerator t
  localparam int ProdW  = 2 * DotW;    // products of dot products
  localparam int MW     = ProdW - 2;   // gram determinant, never negative
  localparam int QW     = CoordW;      // quotient bits, bounded by a coordinate span
  localparam int NumW   = MW + QW;     // divider numerator
  localparam int DistW  = 2 * DiffW + 2; // squared distance, three terms
  localparam int Lanes  = 12;          // four projections, three axes each

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_start_z;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t first_end_z;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_start_z;
    coord_t second_end_x;
    coord_t second_end_y;
    coord_t second_end_z;
  } snp_in_t;

  typedef struct packed {
    logic   found;
    coord_t near_first_x;
    coord_t near_first_y;
    coord_t near_first_z;
    coord_t near_second_x;
    coord_t near_second_y;
    coord_t near_second_z;
  } snp_out_t;

  // how a projected point is formed
  typedef enum logic [1:0] {
    PmLow  = 2'd0,
    PmHigh = 2'd1,
    PmMid  = 2'd2
  } pmode_e;

endpackage

### rtl/segment_nearest_points_unit.sv
// segment_nearest_points_unit: nearest points between two 3d segments, fully pipelined
// depends on snp_pkg, snp_mul, snp_div, snp_delay
//
//   port       | dir | payload       | handshake
//   in_data_i  | in  | snp_in_t      | in_valid_i / in_ready_o
//   out_data_o | out | snp_out_t     | out_valid_o / out_ready_i
//
// one word enters per cycle while in_ready_o is high; the result passes through the
// bit-per-stage dividers and the split multipliers on its way to the output register
// every stage moves together; when the output register is full and not taken,
// the whole pipe holds and in_ready_o drops
// reset clears the valid bits only
`timescale 1ns / 1ps

module segment_nearest_points_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  snp_pkg::snp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output snp_pkg::snp_out_t out_data_o
);

  import snp_pkg::*;

  localparam int PS1 = 0;
  localparam int PE1 = 1;
  localparam int PS2 = 2;
  localparam int PE2 = 3;

  localparam logic [1:0] CandS2 = 2'd0;
  localparam logic [1:0] CandE2 = 2'd1;
  localparam logic [1:0] CandS1 = 2'd2;
  localparam logic [1:0] CandE1 = 2'd3;

  typedef logic [3:0][2:0][CoordW-1:0] pts_t;
  typedef logic [2:0][DiffW-1:0]       dvec_t;

  typedef struct packed {
    pts_t                 pts;
    dvec_t                a;
    dvec_t                b;
    logic [DotW-1:0]      l11;
    logic [DotW-1:0]      l22;
    logic [3:0][TW-1:0]   t;
  } side_a_t;

  typedef struct packed {
    pts_t               pts;
    logic [Lanes-1:0]   neg;
    pmode_e [3:0]       modes;
    logic               interior;
    logic               found;
    logic [MW-1:0]      m;
    logic [LenW-1:0]    l11;
    logic [LenW-1:0]    l22;
  } side_b_t;

  typedef struct packed {
    pts_t               pts;
    logic [Lanes-1:0]   neg;
    pmode_e [3:0]       modes;
    logic               interior;
    logic               found;
  } side_c_t;

  typedef struct packed {
    pts_t pts;
    pts_t qp;
    logic interior;
    logic found;
  } late_t;

  function automatic logic signed [DotW-1:0] dot3(input dvec_t x, input dvec_t y);
    logic signed [2*DiffW-1:0] pr;
    logic signed [DotW-1:0]    acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      pr  = $signed(x[i]) * $signed(y[i]);
      acc = acc + DotW'(pr);
    end
    return acc;
  endfunction

  function automatic logic [DiffW-1:0] sub17(input logic [CoordW-1:0] x,
                                             input logic [CoordW-1:0] y);
    return DiffW'($signed(x)) - DiffW'($signed(y));
  endfunction

  logic pipe_en;

  // stage 1: input register
  logic    v1_q;
  pts_t    pts1;

  // stage 2: differences
  pts_t  pts2_q;
  dvec_t a2_q, b2_q, d2_q;
  logic  v2_q;

  // stage 3: dot products
  pts_t  pts3_q;
  dvec_t a3_q, b3_q;
  logic signed [DotW-1:0] l11_q, l22_q, l12_q, ra_q, rb_q;
  logic  v3_q;
  side_a_t side3;
  logic signed [DotW-1:0]  ma [6];
  logic signed [DotW-1:0]  mb [6];
  logic signed [ProdW-1:0] mp [6];

  // stage 5/6: determinant and numerators
  side_a_t side5;
  logic    v5;
  side_a_t side6_q;
  logic signed [ProdW-1:0] m6_q, na6_q, nb6_q;
  logic    v6_q;
  logic    found6, interior6;
  pmode_e [3:0] mode6;
  logic [Lanes-1:0] neg6;
  logic [Lanes-1:0][CoordW-1:0] mag6;
  logic [Lanes-1:0][ProdW-1:0]  opb6;

  // stage 7: multiplier operands
  logic [Lanes-1:0][CoordW-1:0] mag7_q;
  logic [Lanes-1:0][ProdW-1:0]  opb7_q;
  side_b_t side7_q;
  logic    v7_q;
  logic signed [CoordW+ProdW:0] nprod [Lanes];

  // stage 9: divider inputs
  side_b_t side9;
  logic    v9;
  logic [NumW-1:0] num9 [Lanes];
  logic [MW-1:0]   den9 [Lanes];
  side_c_t side9c;

  // stage 25: quotients
  logic [QW-1:0]      quo [Lanes];
  logic [Lanes-1:0]   rnz;
  side_c_t side25;
  logic    v25;
  logic [Lanes-1:0][CoordW-1:0] val25;
  pts_t    qp25;

  late_t   l26_q;
  logic    v26_q;
  logic [3:0][DistW-1:0] dist26;

  late_t   l27_q;
  logic [3:0][DistW-1:0] dist27_q;
  logic    v27_q;
  logic    w01, w23;

  late_t   l28_q;
  logic [DistW-1:0] d01_q, d23_q;
  logic    w01_q, w23_q, v28_q;
  logic [1:0] win;
  snp_out_t res28;

  snp_out_t out_q;
  logic     out_v_q;

  assign pipe_en    = !out_v_q || out_ready_i;
  assign in_ready_o = pipe_en;

  // ---------------- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      v26_q   <= 1'b0;
      v27_q   <= 1'b0;
      v28_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v6_q    <= v5;
      v7_q    <= v6_q;
      v26_q   <= v25;
      v27_q   <= v26_q;
      v28_q   <= v27_q;
      out_v_q <= v28_q;
    end
  end

  // ---------------- stage 1 to 3
  always_comb begin
    pts1[PS1] = {in_data_i.first_start_z, in_data_i.first_start_y, in_data_i.first_start_x};
    pts1[PE1] = {in_data_i.first_end_z, in_data_i.first_end_y, in_data_i.first_end_x};
    pts1[PS2] = {in_data_i.second_start_z, in_data_i.second_start_y,
                 in_data_i.second_start_x};
    pts1[PE2] = {in_data_i.second_end_z, in_data_i.second_end_y, in_data_i.second_end_x};
  end

  pts_t pts1_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pts1_q <= pts1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pts2_q <= pts1_q;
      for (int i = 0; i < 3; i++) begin
        a2_q[i] <= sub17(pts1_q[PE1][i], pts1_q[PS1][i]);
        b2_q[i] <= sub17(pts1_q[PE2][i], pts1_q[PS2][i]);
        d2_q[i] <= sub17(pts1_q[PS2][i], pts1_q[PS1][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pts3_q <= pts2_q;
      a3_q   <= a2_q;
      b3_q   <= b2_q;
      l11_q  <= dot3(a2_q, a2_q);
      l22_q  <= dot3(b2_q, b2_q);
      l12_q  <= -dot3(a2_q, b2_q);
      ra_q   <= dot3(a2_q, d2_q);
      rb_q   <= -dot3(b2_q, d2_q);
    end
  end

  // ---------------- stage 3 to 5: gram products
  always_comb begin
    ma[0] = l11_q;  mb[0] = l22_q;
    ma[1] = l12_q;  mb[1] = l12_q;
    ma[2] = l22_q;  mb[2] = ra_q;
    ma[3] = l12_q;  mb[3] = rb_q;
    ma[4] = l11_q;  mb[4] = rb_q;
    ma[5] = l12_q;  mb[5] = ra_q;
    side3.pts  = pts3_q;
    side3.a    = a3_q;
    side3.b    = b3_q;
    side3.l11  = l11_q;
    side3.l22  = l22_q;
    // projection numerators reuse the dot products
    side3.t[0] = TW'(ra_q);
    side3.t[1] = TW'(ra_q) - TW'(l12_q);
    side3.t[2] = TW'(rb_q);
    side3.t[3] = TW'(rb_q) - TW'(l12_q);
  end

  for (genvar g = 0; g < 6; g++) begin : g_gram
    snp_mul #(.AW(DotW), .BW(DotW), .CW(DiffW)) u_mul (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .a_i   (ma[g]),
      .b_i   (mb[g]),
      .p_o   (mp[g])
    );
  end

  snp_delay #(.W($bits(side_a_t)), .Depth(2)) u_dly_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v3_q),
    .data_i  (side3),
    .valid_o (v5),
    .data_o  (side5)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side6_q <= side5;
      m6_q    <= mp[0] - mp[1];
      na6_q   <= mp[2] - mp[3];
      nb6_q   <= mp[4] - mp[5];
    end
  end

  // ---------------- stage 6: case decision and lane operands
  assign found6    = |m6_q;
  assign interior6 = found6 && !na6_q[ProdW-1] && (na6_q <= m6_q) &&
                     !nb6_q[ProdW-1] && (nb6_q <= m6_q);

  for (genvar j = 0; j < 4; j++) begin : g_mode
    logic signed [TW-1:0] tj, len;
    assign tj  = $signed(side6_q.t[j]);
    assign len = (j < 2) ? TW'($signed(side6_q.l11)) : TW'($signed(side6_q.l22));
    always_comb begin
      if (interior6) begin
        mode6[j] = PmMid;
      end else if (tj <= 0) begin
        mode6[j] = PmLow;
      end else if (tj >= len) begin
        mode6[j] = PmHigh;
      end else begin
        mode6[j] = PmMid;
      end
    end
  end

  for (genvar k = 0; k < Lanes; k++) begin : g_lane6
    localparam int J = k / 3;
    localparam int C = k % 3;
    logic [DiffW-1:0] dk;
    assign dk      = (J < 2) ? side6_q.a[C] : side6_q.b[C];
    assign neg6[k] = dk[DiffW-1];
    assign mag6[k] = dk[DiffW-1] ? CoordW'(~dk + 1'b1) : CoordW'(dk);
    always_comb begin
      if (interior6 && J == 0) begin
        opb6[k] = na6_q;
      end else if (interior6 && J == 2) begin
        opb6[k] = nb6_q;
      end else begin
        opb6[k] = ProdW'($signed(side6_q.t[J]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mag7_q           <= mag6;
      opb7_q           <= opb6;
      side7_q.pts      <= side6_q.pts;
      side7_q.neg      <= neg6;
      side7_q.modes    <= mode6;
      side7_q.interior <= interior6;
      side7_q.found    <= found6;
      side7_q.m        <= MW'(m6_q);
      side7_q.l11      <= LenW'(side6_q.l11);
      side7_q.l22      <= LenW'(side6_q.l22);
    end
  end

  // ---------------- stage 7 to 9: numerator products
  for (genvar k = 0; k < Lanes; k++) begin : g_nmul
    snp_mul #(.AW(CoordW + 1), .BW(ProdW), .CW(DiffW)) u_mul (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .a_i   ($signed({1'b0, mag7_q[k]})),
      .b_i   ($signed(opb7_q[k])),
      .p_o   (nprod[k])
    );
  end

  snp_delay #(.W($bits(side_b_t)), .Depth(2)) u_dly_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v7_q),
    .data_i  (side7_q),
    .valid_o (v9),
    .data_o  (side9)
  );

  // ---------------- stage 9 to 25: dividers
  for (genvar k = 0; k < Lanes; k++) begin : g_div
    assign num9[k] = NumW'(nprod[k]);
    assign den9[k] = side9.interior ? side9.m :
                     (k < 6) ? MW'(side9.l11) : MW'(side9.l22);
    snp_div #(.NW(NumW), .DW(MW), .QW(QW)) u_div (
      .clk_i    (clk_i),
      .en_i     (pipe_en),
      .num_i    (num9[k]),
      .den_i    (den9[k]),
      .q_o      (quo[k]),
      .rem_nz_o (rnz[k])
    );
  end

  always_comb begin
    side9c.pts      = side9.pts;
    side9c.neg      = side9.neg;
    side9c.modes    = side9.modes;
    side9c.interior = side9.interior;
    side9c.found    = side9.found;
  end

  snp_delay #(.W($bits(side_c_t)), .Depth(QW)) u_dly_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v9),
    .data_i  (side9c),
    .valid_o (v25),
    .data_o  (side25)
  );

  // ---------------- stage 25: floor fix-up, base add
  for (genvar k = 0; k < Lanes; k++) begin : g_lane25
    localparam int J = k / 3;
    localparam int C = k % 3;
    logic signed [QW:0]     fr;
    logic signed [CoordW+1:0] sum;
    logic [CoordW-1:0]      base, far;
    assign base = (J < 2) ? side25.pts[PS1][C] : side25.pts[PS2][C];
    assign far  = (J < 2) ? side25.pts[PE1][C] : side25.pts[PE2][C];
    // negative direction: floor rounds away from zero when inexact
    assign fr   = side25.neg[k] ? -$signed({1'b0, quo[k]}) - $signed({{QW{1'b0}}, rnz[k]})
                                :  $signed({1'b0, quo[k]});
    assign sum  = (CoordW+2)'($signed(base)) + (CoordW+2)'(fr);
    assign val25[k] = CoordW'(sum);
    always_comb begin
      case (side25.modes[J])
        PmLow:   qp25[J][C] = base;
        PmHigh:  qp25[J][C] = far;
        PmMid:   qp25[J][C] = val25[k];
        default: qp25[J][C] = base;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      l26_q.pts      <= side25.pts;
      l26_q.qp       <= qp25;
      l26_q.interior <= side25.interior;
      l26_q.found    <= side25.found;
    end
  end

  // ---------------- stage 26: squared distances
  for (genvar j = 0; j < 4; j++) begin : g_dist
    localparam int PJ = (j == 0) ? PS2 : (j == 1) ? PE2 : (j == 2) ? PS1 : PE1;
    always_comb begin
      logic signed [DiffW-1:0]   df;
      logic signed [2*DiffW-1:0] sq;
      logic [DistW-1:0]          acc;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        df  = sub17(l26_q.pts[PJ][i], l26_q.qp[j][i]);
        sq  = df * df;
        acc = acc + DistW'(unsigned'(sq));
      end
      dist26[j] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      l27_q    <= l26_q;
      dist27_q <= dist26;
    end
  end

  // ---------------- stage 27/28: later candidate wins ties
  assign w01 = dist27_q[1] <= dist27_q[0];
  assign w23 = dist27_q[3] <= dist27_q[2];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      l28_q <= l27_q;
      w01_q <= w01;
      w23_q <= w23;
      d01_q <= w01 ? dist27_q[1] : dist27_q[0];
      d23_q <= w23 ? dist27_q[3] : dist27_q[2];
    end
  end

  assign win = (d23_q <= d01_q) ? (w23_q ? CandE1 : CandS1) : (w01_q ? CandE2 : CandS2);

  always_comb begin
    pts_t             p;
    logic [2:0][CoordW-1:0] n1, n2;
    p = l28_q.pts;
    case (win)
      CandS2:  begin n1 = l28_q.qp[0]; n2 = p[PS2]; end
      CandE2:  begin n1 = l28_q.qp[1]; n2 = p[PE2]; end
      CandS1:  begin n1 = p[PS1]; n2 = l28_q.qp[2]; end
      CandE1:  begin n1 = p[PE1]; n2 = l28_q.qp[3]; end
      default: begin n1 = l28_q.qp[0]; n2 = p[PS2]; end
    endcase
    if (l28_q.interior) begin
      n1 = l28_q.qp[0];
      n2 = l28_q.qp[2];
    end
    if (!l28_q.found) begin
      n1 = '0;
      n2 = '0;
    end
    res28.found         = l28_q.found;
    res28.near_first_x  = n1[0];
    res28.near_first_y  = n1[1];
    res28.near_first_z  = n1[2];
    res28.near_second_x = n2[0];
    res28.near_second_y = n2[1];
    res28.near_second_z = n2[2];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q <= res28;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ---------------- checks
  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      out_data_o.near_first_x == '0 && out_data_o.near_first_y == '0 &&
      out_data_o.near_first_z == '0 && out_data_o.near_second_x == '0 &&
      out_data_o.near_second_y == '0 && out_data_o.near_second_z == '0)
    else $error("parallel result carries nonzero points");

  a_interior_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q && side7_q.interior |-> side7_q.found)
    else $error("interior case flagged without a solution");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(side6_q) && $stable(v6_q) && $stable(v28_q))
    else $error("pipeline moved while stalled");

endmodule

### rtl/snp_mul.sv
// snp_mul: two-stage signed multiplier, magnitude split into chunk partial products
// depends on nothing; used by segment_nearest_points_unit
`timescale 1ns / 1ps

module snp_mul #(
  parameter int AW = 17,
  parameter int BW = 17,
  parameter int CW = 17
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int NC = (BW + CW - 1) / CW;
  localparam int PW = AW + NC * CW;

  logic [AW-1:0]      am;
  logic [NC*CW-1:0]   bm;
  logic [AW+CW-1:0]   pp_q [NC];
  logic               neg_q;
  logic [PW-1:0]      acc;
  logic [AW+BW-1:0]   p_q;

  always_comb begin
    am = a_i[AW-1] ? AW'(~a_i + 1'b1) : AW'(a_i);
    bm = b_i[BW-1] ? (NC*CW)'(BW'(~b_i + 1'b1)) : (NC*CW)'(BW'(b_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NC; k++) begin
        pp_q[k] <= (AW+CW)'(am) * (AW+CW)'(bm[k*CW +: CW]);
      end
      neg_q <= a_i[AW-1] ^ b_i[BW-1];
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NC; k++) begin
      acc = acc + (PW'(pp_q[k]) << (k * CW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg_q ? (AW+BW)'(~acc + 1'b1) : (AW+BW)'(acc);
    end
  end

  assign p_o = $signed(p_q);

endmodule

### rtl/snp_div.sv
// snp_div: pipelined restoring divider, one quotient bit per register stage
// depends on nothing; needs num < den * 2**QW; used by segment_nearest_points_unit
`timescale 1ns / 1ps

module snp_div #(
  parameter int NW = 84,
  parameter int DW = 68,
  parameter int QW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] q_o,
  output logic          rem_nz_o
);

  logic [NW-1:0] rem_q [QW];
  logic [QW-1:0] q_q   [QW];
  logic [DW-1:0] den_q [QW-1];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [NW-1:0] trial;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign q_in   = q_q[s-1];
    end

    assign trial = NW'(den_in) << (QW - 1 - s);
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? rem_in - trial : rem_in;
        q_q[s]   <= q_in | (QW'(ge) << (QW - 1 - s));
      end
    end

    if (s < QW - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign q_o      = q_q[QW-1];
  assign rem_nz_o = |rem_q[QW-1];

endmodule

### rtl/snp_delay.sv
// snp_delay: fixed-depth register line for a valid bit and its sideband word
// depends on nothing; keeps side data aligned with the multiplier and divider pipes
`timescale 1ns / 1ps

module snp_delay #(
  parameter int W     = 8,
  parameter int Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [Depth-1:0] valid_q;
  logic [W-1:0]     data_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= data_i;
      for (int k = 1; k < Depth; k++) begin
        data_q[k] <= data_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[Depth-1];
  assign data_o  = data_q[Depth-1];

endmodule
